// ===== design/jre_pkg.sv =====
// ----------------------------------------------------------------------------
// jre_pkg - shared types and constants of the jet resolution evaluator
// Table geometry, status and command codes, and the item passed from the
// front part to the arithmetic pipeline.
// ----------------------------------------------------------------------------
package jre_pkg;

  // table geometry: 96 words kept as 24 rows of four coefficients
  localparam int TableDepth = 96;
  localparam int TableRows  = TableDepth / 4;
  localparam int RowW       = $clog2(TableRows);
  localparam int IdxW       = 7;
  localparam int CoefW      = 32;
  localparam int RowBits    = 4 * CoefW;

  // input item packing in s_tdata
  localparam int InDataW  = 96;
  localparam int OutDataW = 40;

  // arithmetic pipeline timing
  localparam int DivSteps  = 64;
  localparam int SqrtSteps = 24;
  localparam int DivFirst  = 2;
  localparam int DivLast   = DivFirst + DivSteps - 1;
  localparam int SqFirst   = 2;
  localparam int SqLast    = SqFirst + SqrtSteps - 1;
  localparam int MulStage  = SqLast + 1;
  localparam int SumStage  = DivLast + 1;
  localparam int OutStage  = SumStage + 1;
  localparam int PipeLen   = OutStage + 1;

  // |eta| bin edges, scaled so the compares stay exact
  localparam logic [19:0] EtaEdge0x5  = 20'd28672;
  localparam logic [19:0] EtaEdge1x10 = 20'd69632;
  localparam logic [19:0] EtaEdge2x5  = 20'd53248;

  // term magnitude clamp and saturated limits
  localparam logic [63:0] TermClamp = 64'h0004_0000_0000_0000;
  localparam logic [31:0] SatMax    = 32'h7FFF_FFFF;
  localparam logic [31:0] SatMin    = 32'h8000_0000;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  localparam logic [1:0] QTY_NONE   = 2'd0;
  localparam logic [1:0] KIND_LIGHT = 2'd1;
  localparam logic [1:0] KIND_B     = 2'd2;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_QTY    = 2'd1,
    ST_NOT_LOADED = 2'd2,
    ST_BAD_KIND   = 2'd3
  } status_t;

  // classified item handed to the arithmetic pipeline
  typedef struct packed {
    logic        evalf;
    status_t     status;
    logic        ezero;
    logic [31:0] e;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } job_t;

endpackage

// ===== design/jre_front.sv =====
// ----------------------------------------------------------------------------
// jre_front - input side of the jet resolution evaluator
// Accepts items, stores coefficient writes, classifies evaluate items and
// reads their coefficient row from the table.
// ----------------------------------------------------------------------------
module jre_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [jre_pkg::InDataW-1:0] s_tdata,  // coeff_index, coeff_value, eta,
                                                // energy, jet_kind, quantity
  input  logic                        s_tuser,  // command
  input  logic                        full,
  output logic                        push,
  output jre_pkg::job_t               job
);

  logic                             acc;
  logic [jre_pkg::IdxW-1:0]         idx;
  logic [31:0]                      value;
  logic [15:0]                      eta;
  logic [31:0]                      energy;
  logic [1:0]                       kind;
  logic [1:0]                       qty;
  logic [15:0]                      ae;
  logic [19:0]                      ae5;
  logic [19:0]                      ae10;
  logic [1:0]                       bin;
  logic [jre_pkg::RowW-1:0]         row;
  jre_pkg::status_t                 st;
  logic                             wr_ok;

  logic [jre_pkg::RowBits-1:0]      mem [jre_pkg::TableRows];
  logic [jre_pkg::TableDepth-1:0]   vbit;
  logic [3:0]                       nz;

  logic                             f_vld;
  logic                             f_evalf;
  jre_pkg::status_t                 f_status;
  logic [31:0]                      f_e;
  logic [jre_pkg::RowBits-1:0]      f_row;
  logic [3:0]                       f_vmask;

  // field unpacking
  assign idx    = s_tdata[6:0];
  assign value  = s_tdata[38:7];
  assign eta    = s_tdata[54:39];
  assign energy = s_tdata[86:55];
  assign kind   = s_tdata[88:87];
  assign qty    = s_tdata[90:89];

  assign push     = f_vld && !full;
  assign s_tready = !f_vld || !full;
  assign acc      = s_tvalid && s_tready;
  assign wr_ok    = (s_tuser == jre_pkg::CMD_WRITE) &&
                    (idx < jre_pkg::IdxW'(jre_pkg::TableDepth));

  // |eta| binning and table row
  always_comb begin
    ae   = eta[15] ? 16'(-eta) : eta;
    ae5  = {2'b00, ae, 2'b00} + {4'b0000, ae};
    ae10 = {ae5[18:0], 1'b0};
    if (ae5 < jre_pkg::EtaEdge0x5)       bin = 2'd0;
    else if (ae10 < jre_pkg::EtaEdge1x10) bin = 2'd1;
    else if (ae5 < jre_pkg::EtaEdge2x5)   bin = 2'd2;
    else                                  bin = 2'd3;
    row = {2'(qty - 2'd1), kind[1], bin};
  end

  // error checks in priority order
  always_comb begin
    if (s_tuser == jre_pkg::CMD_WRITE)                      st = jre_pkg::ST_OK;
    else if (qty == jre_pkg::QTY_NONE)                      st = jre_pkg::ST_BAD_QTY;
    else if (nz == 4'b0000)                                 st = jre_pkg::ST_NOT_LOADED;
    else if (kind != jre_pkg::KIND_LIGHT && kind != jre_pkg::KIND_B)
                                                            st = jre_pkg::ST_BAD_KIND;
    else                                                    st = jre_pkg::ST_OK;
  end

  // coefficient memory: word write, row read
  always_ff @(posedge clk) begin
    if (acc && wr_ok) begin
      mem[idx[6:2]][idx[1:0]*32 +: 32] <= value;
    end
    if (acc) begin
      f_row   <= mem[row];
      f_vmask <= vbit[row*4 +: 4];
    end
  end

  // written flags and nonzero marks of the first row
  always_ff @(posedge clk) begin
    if (rst) begin
      vbit <= '0;
      nz   <= '0;
    end else if (acc && wr_ok) begin
      vbit[idx] <= 1'b1;
      if (idx < jre_pkg::IdxW'(4)) begin
        nz[idx[1:0]] <= (value != 32'd0);
      end
    end
  end

  // front register
  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (s_tready) begin
      f_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      f_evalf  <= (s_tuser == jre_pkg::CMD_EVAL) && (st == jre_pkg::ST_OK);
      f_status <= st;
      f_e      <= energy;
    end
  end

  // item toward the queue, unwritten words read as zero
  always_comb begin
    job.evalf  = f_evalf;
    job.status = f_status;
    job.e      = f_e;
    job.ezero  = (f_e == 32'd0);
    job.a      = f_vmask[0] ? f_row[31:0]   : 32'd0;
    job.b      = f_vmask[1] ? f_row[63:32]  : 32'd0;
    job.c      = f_vmask[2] ? f_row[95:64]  : 32'd0;
    job.d      = f_vmask[3] ? f_row[127:96] : 32'd0;
  end

endmodule

// ===== design/jre_queue.sv =====
// ----------------------------------------------------------------------------
// jre_queue - short queue between front and arithmetic pipeline
// Four entries of classified items, first in first out.
// ----------------------------------------------------------------------------
module jre_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jre_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output jre_pkg::job_t head
);

  jre_pkg::job_t q [4];
  logic [1:0]    wp;
  logic [1:0]    rp;
  logic [2:0]    cnt;

  assign full  = (cnt == 3'd4);
  assign empty = (cnt == 3'd0);
  assign head  = q[rp];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (pop)  rp <= rp + 2'd1;
      if (push && !pop)      cnt <= cnt + 3'd1;
      else if (pop && !push) cnt <= cnt - 3'd1;
    end
  end

endmodule

// ===== design/jre_back.sv =====
// ----------------------------------------------------------------------------
// jre_back - arithmetic pipeline of the jet resolution evaluator
// Square root, two dividers one bit per stage, a multiplier, the sum and
// saturation; the last stage is the output register.
// ----------------------------------------------------------------------------
module jre_back (
  input  logic                         clk,
  input  logic                         rst,
  input  jre_pkg::job_t                head,
  input  logic                         empty,
  output logic                         pop,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [jre_pkg::OutDataW-1:0] m_tdata   // resolution, status
);

  typedef struct packed {
    logic             evalf;
    jre_pkg::status_t status;
    logic             ezero;
    logic [31:0]      a;
    logic [31:0]      b;
    logic [31:0]      c;
    logic [31:0]      d;
    logic [31:0]      e;
    logic [63:0]      esq;
    logic [47:0]      sx;
    logic [25:0]      srem;
    logic [23:0]      sroot;
    logic [55:0]      prod;
    logic [63:0]      cdv;
    logic [63:0]      crem;
    logic [63:0]      cq;
    logic [63:0]      ddv;
    logic [63:0]      drem;
    logic [63:0]      dq;
    logic [53:0]      sum;
    logic [31:0]      res;
  } stage_t;

  stage_t                      pipe [jre_pkg::PipeLen];
  logic [jre_pkg::PipeLen-1:0] vld;
  logic                        adv;
  stage_t                      entry;

  function automatic logic [31:0] mag32(logic [31:0] x);
    return x[31] ? 32'(-x) : x;
  endfunction

  // work of one stage, chosen by its place in the pipeline
  function automatic stage_t step(stage_t p, int k);
    stage_t      n;
    logic [64:0] t;
    logic [27:0] sr;
    logic [27:0] trial;
    logic [63:0] qb;
    logic [63:0] qc;
    logic [63:0] qd;
    logic [53:0] vb;
    logic [53:0] vc;
    logic [53:0] vd;
    n = p;
    if (k == 1) begin
      n.esq   = 64'(p.e) * 64'(p.e);
      n.cdv   = {16'd0, mag32(p.c), 16'd0};
      n.ddv   = {mag32(p.d), 32'd0};
      n.crem  = '0;
      n.drem  = '0;
      n.cq    = '0;
      n.dq    = '0;
      n.sx    = {p.e, 16'd0};
      n.srem  = '0;
      n.sroot = '0;
    end
    // restoring division, one quotient bit per stage
    if (k >= jre_pkg::DivFirst && k <= jre_pkg::DivLast) begin
      t = {p.crem, p.cdv[63]};
      if (t >= {33'd0, p.e}) begin
        t = t - {33'd0, p.e};
        n.cq = {p.cq[62:0], 1'b1};
      end else begin
        n.cq = {p.cq[62:0], 1'b0};
      end
      n.crem = t[63:0];
      n.cdv  = {p.cdv[62:0], 1'b0};
      t = {p.drem, p.ddv[63]};
      if (t >= {1'b0, p.esq}) begin
        t = t - {1'b0, p.esq};
        n.dq = {p.dq[62:0], 1'b1};
      end else begin
        n.dq = {p.dq[62:0], 1'b0};
      end
      n.drem = t[63:0];
      n.ddv  = {p.ddv[62:0], 1'b0};
    end
    // digit-by-digit square root, one root bit per stage
    if (k >= jre_pkg::SqFirst && k <= jre_pkg::SqLast) begin
      sr    = {p.srem, p.sx[47:46]};
      trial = {2'b00, p.sroot, 2'b01};
      if (sr >= trial) begin
        n.srem  = 26'(sr - trial);
        n.sroot = {p.sroot[22:0], 1'b1};
      end else begin
        n.srem  = sr[25:0];
        n.sroot = {p.sroot[22:0], 1'b0};
      end
      n.sx = {p.sx[45:0], 2'b00};
    end
    if (k == jre_pkg::MulStage) begin
      n.prod = 56'(mag32(p.b)) * 56'(p.sroot);
    end
    // floor-rounded terms, clamp of the D/E^2 term, sum
    if (k == jre_pkg::SumStage) begin
      qb = {24'd0, p.prod[55:16]};
      if (p.b[31] && p.prod[15:0] != 16'd0) qb = qb + 64'd1;
      qc = p.cq;
      if (p.c[31] && p.crem != 64'd0) qc = qc + 64'd1;
      qd = p.dq;
      if (p.d[31] && p.drem != 64'd0) qd = qd + 64'd1;
      if (qd > jre_pkg::TermClamp) qd = jre_pkg::TermClamp;
      vb = p.b[31] ? 54'(-qb) : qb[53:0];
      vc = p.c[31] ? 54'(-qc) : qc[53:0];
      vd = p.d[31] ? 54'(-qd) : qd[53:0];
      n.sum = {{22{p.a[31]}}, p.a} + vb + vc + vd;
    end
    // saturation and result select
    if (k == jre_pkg::OutStage) begin
      if (!p.evalf) begin
        n.res = (p.status == jre_pkg::ST_OK) ? 32'd0 : jre_pkg::SatMax;
      end else if (p.ezero) begin
        n.res = p.a;
      end else if ($signed(p.sum) > $signed({22'd0, jre_pkg::SatMax})) begin
        n.res = jre_pkg::SatMax;
      end else if ($signed(p.sum) < $signed({{22{1'b1}}, jre_pkg::SatMin})) begin
        n.res = jre_pkg::SatMin;
      end else begin
        n.res = p.sum[31:0];
      end
    end
    return n;
  endfunction

  assign adv = !vld[jre_pkg::PipeLen-1] || m_tready;
  assign pop = adv && !empty;

  // valid bits of the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[jre_pkg::PipeLen-2:0], !empty};
    end
  end

  // entry stage contents from the queue head
  always_comb begin
    entry        = '0;
    entry.evalf  = head.evalf;
    entry.status = head.status;
    entry.ezero  = head.ezero;
    entry.a      = head.a;
    entry.b      = head.b;
    entry.c      = head.c;
    entry.d      = head.d;
    entry.e      = head.e;
  end

  // entry stage
  always_ff @(posedge clk) begin
    if (adv) begin
      pipe[0] <= entry;
    end
  end

  // working stages
  for (genvar k = 1; k < jre_pkg::PipeLen; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (adv) begin
        pipe[k] <= step(pipe[k-1], k);
      end
    end
  end

  assign m_tvalid = vld[jre_pkg::PipeLen-1];
  assign m_tdata  = {6'd0, pipe[jre_pkg::PipeLen-1].status,
                     pipe[jre_pkg::PipeLen-1].res};

endmodule

// ===== design/jet_resolution_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// jet_resolution_evaluator_top - jet resolution evaluator
// Coefficient table with write items and a pipelined A+B*sqrt(E)+C/E+D/E^2.
// ----------------------------------------------------------------------------
// Use: items enter on the s_ stream; s_tuser selects a coefficient write (0)
// or an evaluation (1). Every item gives exactly one result on the m_ stream,
// in order: resolution (Q16.16, saturated) and a status code. A write returns
// resolution 0 and status ok.
// An accepted item passes the front register (table read and classification),
// the queue and then the pipeline stages, whose number is set mainly by the
// two 64-step restoring dividers (one quotient bit per stage).
// Throughput is one item per cycle while nothing stalls; a write may be
// followed at once by an evaluation that uses it.
// Reset clears the table (all words read as zero) and empties the pipeline.
// When m_tready is low and a result waits, the pipeline holds, the four-entry
// queue fills, and s_tready drops once the queue and front register are full.
// ----------------------------------------------------------------------------
module jet_resolution_evaluator_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [jre_pkg::InDataW-1:0]  s_tdata,   // coeff_index[6:0], coeff_value[38:7],
                                                  // eta[54:39], energy[86:55],
                                                  // jet_kind[88:87], quantity[90:89]
  input  logic                         s_tuser,   // command
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [jre_pkg::OutDataW-1:0] m_tdata    // resolution[31:0], status[33:32]
);

  jre_pkg::job_t fjob;
  jre_pkg::job_t head;
  logic          push;
  logic          full;
  logic          pop;
  logic          empty;

  jre_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .full     (full),
    .push     (push),
    .job      (fjob)
  );

  jre_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (fjob),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  jre_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== sim/tb_jet_resolution_evaluator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_jet_resolution_evaluator_top - jet resolution evaluator testbench
// Loads the coefficient table with write items and sends evaluate items, first
// from a directed table and then at random. Each result is compared with a
// typed expectation or the bench predictor. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_jet_resolution_evaluator_top;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [jre_pkg::InDataW-1:0]  s_tdata = '0;
  logic                         s_tuser = 1'b0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [jre_pkg::OutDataW-1:0] m_tdata;

  jet_resolution_evaluator_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  typedef struct {
    logic        cmd;
    logic [6:0]  idx;
    logic [31:0] val;
    logic [15:0] eta;
    logic [31:0] en;
    logic [1:0]  kind;
    logic [1:0]  qty;
  } jet_item_t;

  typedef struct {
    logic [31:0]      res;
    jre_pkg::status_t st;
  } res_item_t;

  // directed row: item, plus a typed expectation where known
  typedef struct {
    jet_item_t        it;
    logic             known;
    logic [31:0]      res;
    jre_pkg::status_t st;
  } dir_row_t;

  logic [31:0] coef_mirror [jre_pkg::TableDepth];
  res_item_t   expected_q[$];
  int          errors = 0;
  int          cycles = 0;

  function automatic logic [63:0] isqrt(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // floor of signed quotient, magnitude clamped
  function automatic longint term_div(input bit neg, input logic [63:0] mag,
                                      input logic [63:0] den);
    logic [63:0] q;
    q = mag / den;
    if (neg && (mag % den) != 0) q = q + 1;
    if (q > jre_pkg::TermClamp) q = jre_pkg::TermClamp;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [63:0] mag64(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // resolution predictor; updates the table mirror on writes
  function automatic res_item_t predict_resolution(input jet_item_t it);
    res_item_t   r;
    logic [15:0] ae;
    int          bin, base;
    longint      a, b, c, d, tb, tc, td, sum;
    logic [63:0] s, e;
    r.res = '0;
    r.st = jre_pkg::ST_OK;
    if (it.cmd == jre_pkg::CMD_WRITE) begin
      if (it.idx < jre_pkg::TableDepth) coef_mirror[it.idx] = it.val;
    end else if (it.qty == jre_pkg::QTY_NONE) begin
      r.res = jre_pkg::SatMax; r.st = jre_pkg::ST_BAD_QTY;
    end else if (coef_mirror[0] == 0 && coef_mirror[1] == 0 &&
                 coef_mirror[2] == 0 && coef_mirror[3] == 0) begin
      r.res = jre_pkg::SatMax; r.st = jre_pkg::ST_NOT_LOADED;
    end else if (it.kind != jre_pkg::KIND_LIGHT && it.kind != jre_pkg::KIND_B) begin
      r.res = jre_pkg::SatMax; r.st = jre_pkg::ST_BAD_KIND;
    end else begin
      ae = it.eta[15] ? -it.eta : it.eta;
      if (ae * 5 < jre_pkg::EtaEdge0x5) bin = 0;
      else if (ae * 10 < jre_pkg::EtaEdge1x10) bin = 1;
      else if (ae * 5 < jre_pkg::EtaEdge2x5) bin = 2;
      else bin = 3;
      base = (((it.qty - 1) * 2 + it.kind - 1) * 16 + bin * 4) % jre_pkg::TableDepth;
      a = longint'($signed(coef_mirror[base]));
      b = longint'($signed(coef_mirror[base+1]));
      c = longint'($signed(coef_mirror[base+2]));
      d = longint'($signed(coef_mirror[base+3]));
      e = {32'd0, it.en};
      if (e == 0) begin
        sum = a;
      end else begin
        s = isqrt(e << 16);
        tb = term_div(b < 0, mag64(b) * s, 64'd65536);
        tc = term_div(c < 0, mag64(c) << 16, e);
        td = term_div(d < 0, mag64(d) << 32, e * e);
        sum = a + tb + tc + td;
      end
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      r.res = sum[31:0];
    end
    return r;
  endfunction

  function automatic jet_item_t wr_item(input int idx, input logic [31:0] v);
    jet_item_t it;
    it = '{cmd: jre_pkg::CMD_WRITE, idx: idx[6:0], val: v, eta: '0, en: '0,
           kind: '0, qty: '0};
    return it;
  endfunction

  function automatic jet_item_t ev_item(input logic [15:0] eta, input logic [31:0] en,
                                        input logic [1:0] kind, input logic [1:0] qty);
    jet_item_t it;
    it = '{cmd: jre_pkg::CMD_EVAL, idx: '0, val: '0, eta: eta, en: en, kind: kind,
           qty: qty};
    return it;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // drive one item; the predictor runs on acceptance, valid stays up for the next
  task automatic send_item(input jet_item_t it, input bit has_exp, input res_item_t ex);
    res_item_t p;
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tuser  <= it.cmd;
    s_tdata  <= {5'd0, it.qty, it.kind, it.en, it.eta, it.val, it.idx};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    p = predict_resolution(it);
    if (has_exp && (p.res !== ex.res || p.st !== ex.st))
      $display("%0t typed row differs from predictor: %h/%0d vs %h/%0d",
               $time, ex.res, ex.st, p.res, p.st);
    expected_q.push_back(has_exp ? ex : p);
    @(negedge clk);
  endtask

  // stop sending and wait until every expected result has come
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (expected_q.size() != 0);
  endtask

  // receive side with random stalls
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if ($urandom_range(0, 29) == 0) m_tready <= 1'b0;
    else if ($urandom_range(0, 3) == 0) m_tready <= ~m_tready;
    else if (!m_tready && $urandom_range(0, 1) == 0) m_tready <= 1'b1;
  end

  // result checker
  always @(posedge clk) begin
    res_item_t ex;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, m_tdata);
        errors++;
      end else begin
        ex = expected_q.pop_front();
        if (m_tdata[31:0] !== ex.res) begin
          $display("%0t resolution expected %h actual %h", $time, ex.res, m_tdata[31:0]);
          errors++;
        end
        if (m_tdata[33:32] !== ex.st) begin
          $display("%0t status expected %0d actual %0d", $time, ex.st, m_tdata[33:32]);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("FAIL jet_resolution_evaluator_top");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      3: return $urandom_range(0, 131071) - 65536;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_energy();
    case ($urandom_range(0, 6))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 16);
      3: return $urandom_range(1, 1000) << 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_eta();
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'($urandom_range(0, 14000)) ^ ($urandom_range(0, 1) ? 16'hFFFF : 16'h0);
      default: return $urandom;
    endcase
  endfunction

  dir_row_t  dir_rows[$];
  res_item_t none_ex;
  res_item_t ex;
  int        n;

  initial begin
    none_ex = '{res: '0, st: jre_pkg::ST_OK};
    foreach (coef_mirror[i]) coef_mirror[i] = '0;
    // directed table
    dir_rows.push_back('{ev_item(16'h0, 32'd100, jre_pkg::KIND_LIGHT, jre_pkg::QTY_NONE),
                         1, jre_pkg::SatMax, jre_pkg::ST_BAD_QTY});
    dir_rows.push_back('{ev_item(16'h0, 32'd100, jre_pkg::KIND_LIGHT, 2'd1),
                         1, jre_pkg::SatMax, jre_pkg::ST_NOT_LOADED});
    dir_rows.push_back('{wr_item(127, 32'h1234), 1, 32'd0, jre_pkg::ST_OK});
    dir_rows.push_back('{ev_item(16'h0, 32'd0, jre_pkg::KIND_LIGHT, 2'd1),
                         1, jre_pkg::SatMax, jre_pkg::ST_NOT_LOADED});
    dir_rows.push_back('{wr_item(0, 32'h0001_0000), 1, 32'd0, jre_pkg::ST_OK});
    dir_rows.push_back('{ev_item(16'h0, 32'd0, 2'd0, 2'd1),
                         1, jre_pkg::SatMax, jre_pkg::ST_BAD_KIND});
    dir_rows.push_back('{ev_item(16'h0, 32'd0, 2'd3, 2'd3),
                         1, jre_pkg::SatMax, jre_pkg::ST_BAD_KIND});
    dir_rows.push_back('{ev_item(16'h0, 32'd0, jre_pkg::KIND_LIGHT, 2'd1),
                         1, 32'h0001_0000, jre_pkg::ST_OK});
    dir_rows.push_back('{wr_item(1, 32'h7FFF_FFFF), 1, 32'd0, jre_pkg::ST_OK});
    dir_rows.push_back('{wr_item(2, 32'h8000_0000), 1, 32'd0, jre_pkg::ST_OK});
    dir_rows.push_back('{wr_item(3, 32'h7FFF_FFFF), 1, 32'd0, jre_pkg::ST_OK});
    dir_rows.push_back('{ev_item(16'h0, 32'hFFFF_FFFF, jre_pkg::KIND_LIGHT, 2'd1),
                         0, 0, jre_pkg::ST_OK});
    dir_rows.push_back('{ev_item(16'h0, 32'd1, jre_pkg::KIND_LIGHT, 2'd1),
                         0, 0, jre_pkg::ST_OK});
    dir_rows.push_back('{wr_item(95, 32'h8000_0000), 1, 32'd0, jre_pkg::ST_OK});
    dir_rows.push_back('{wr_item(92, 32'h0003_0000), 1, 32'd0, jre_pkg::ST_OK});
    dir_rows.push_back('{ev_item(16'h7FFF, 32'd0, jre_pkg::KIND_B, 2'd3),
                         1, 32'h0003_0000, jre_pkg::ST_OK});
    dir_rows.push_back('{ev_item(16'h8000, 32'd5, jre_pkg::KIND_B, 2'd3),
                         0, 0, jre_pkg::ST_OK});
    // bin edges: 5734, 6963 and 10649 sit just below 1.4, 1.7 and 2.6;
    // 5735 and 10650 sit just past 1.4 and 2.6
    dir_rows.push_back('{ev_item(16'd5734, 32'h0004_0000, jre_pkg::KIND_LIGHT, 2'd2),
                         0, 0, jre_pkg::ST_OK});
    dir_rows.push_back('{ev_item(-16'd5735, 32'h0004_0000, jre_pkg::KIND_B, 2'd2),
                         0, 0, jre_pkg::ST_OK});
    dir_rows.push_back('{ev_item(16'd6963, 32'h0004_0000, jre_pkg::KIND_LIGHT, 2'd1),
                         0, 0, jre_pkg::ST_OK});
    dir_rows.push_back('{ev_item(16'd10649, 32'h0004_0000, jre_pkg::KIND_LIGHT, 2'd1),
                         0, 0, jre_pkg::ST_OK});
    dir_rows.push_back('{ev_item(16'd10650, 32'h0004_0000, jre_pkg::KIND_LIGHT, 2'd1),
                         0, 0, jre_pkg::ST_OK});
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      ex = '{res: dir_rows[i].res, st: dir_rows[i].st};
      send_item(dir_rows[i].it, dir_rows[i].known, ex);
    end
    // random part: fill the table mostly, then mostly evaluate
    for (n = 0; n < 700; n++) begin
      if (n == 350) begin
        // let the pipeline drain completely before going on
        drain();
      end
      if (n == 500) begin
        // clear the load marker words to revisit the not-loaded check
        for (int k = 0; k < 4; k++) send_item(wr_item(k, 32'd0), 0, none_ex);
      end
      if ($urandom_range(0, 9) < (n < 120 ? 7 : 3))
        send_item(wr_item($urandom_range(0, 20) == 0 ? $urandom_range(96, 127)
                          : $urandom_range(0, 95), rand_coef()), 0, none_ex);
      else
        send_item(ev_item(rand_eta(), rand_energy(),
                          $urandom_range(0, 9) == 0 ? 2'($urandom_range(0, 3))
                          : 2'($urandom_range(1, 2)),
                          $urandom_range(0, 11) == 0 ? jre_pkg::QTY_NONE
                          : 2'($urandom_range(1, 3))),
                  0, none_ex);
    end
    drain();
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("PASS jet_resolution_evaluator_top");
    end else begin
      $display("FAIL jet_resolution_evaluator_top");
    end
    $finish;
  end
endmodule
